@@ sv/rgi_pkg.sv @@
// ----------------------------------------------------------------------------
// rgi_pkg
// Shared types and constants for the readability grade index block.
// ----------------------------------------------------------------------------
package rgi_pkg;

    localparam int COUNT_WIDTH = 16;

    localparam int CNT_W  = COUNT_WIDTH;
    localparam int PA_W   = 2 * CNT_W;
    localparam int MB_W   = (CNT_W > 12) ? CNT_W : 12;
    localparam int PROD_W = PA_W + MB_W;
    localparam int VAL_W  = 2 * CNT_W + 12;

    localparam int GRADE_W = 4;

    localparam logic [MB_W-1:0] K_CHARS = MB_W'(471);
    localparam logic [MB_W-1:0] K_WORDS = MB_W'(50);
    localparam logic [MB_W-1:0] K_STEP  = MB_W'(100);
    localparam logic [MB_W-1:0] K_BASE  = MB_W'(2243);

    localparam logic [GRADE_W-1:0] GRADE_MAX = GRADE_W'(13);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [GRADE_W-1:0] grade_index;
        logic               count_error;
        logic               count_saturated;
    } out_item_t;

    typedef struct packed {
        logic [CNT_W-1:0] chars;
        logic [CNT_W-1:0] words;
        logic [CNT_W-1:0] sents;
        logic             saturated;
    } counts_t;

    typedef struct packed {
        logic            en;
        logic [PA_W-1:0] a;
        logic [MB_W-1:0] b;
    } mul_req_t;

endpackage

@@ sv/rgi_counters.sv @@
// ----------------------------------------------------------------------------
// rgi_counters
// Classifies each text byte and keeps the saturating character, word and
// sentence counters together with the sticky saturation flag.
// ----------------------------------------------------------------------------
module rgi_counters (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       text_byte,
    input  logic             clear,
    output rgi_pkg::counts_t counts
);
    import rgi_pkg::*;

    logic [CNT_W-1:0] chars_reg, chars_next;
    logic [CNT_W-1:0] words_reg, words_next;
    logic [CNT_W-1:0] sents_reg, sents_next;
    logic             sat_reg, sat_next;
    logic             is_alnum, is_space, is_mark;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    always_comb
    begin
        is_alnum = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                   ((text_byte >= 8'h41) && (text_byte <= 8'h5A)) ||
                   ((text_byte >= 8'h30) && (text_byte <= 8'h39));
        is_space = (text_byte == 8'h20);
        is_mark  = (text_byte == 8'h2E) || (text_byte == 8'h3F) ||
                   (text_byte == 8'h21);
    end

    always_comb
    begin
        chars_next = chars_reg;
        words_next = words_reg;
        sents_next = sents_reg;
        sat_next   = sat_reg;
        if (clear)
        begin
            chars_next = '0;
            words_next = '0;
            sents_next = '0;
            sat_next   = 1'b0;
        end
        else if (accept)
        begin
            if (is_alnum)
            begin
                if (chars_reg == CNT_MAX)
                    sat_next = 1'b1;
                else
                    chars_next = chars_reg + CNT_W'(1);
            end
            else if (is_space)
            begin
                if (words_reg == CNT_MAX)
                    sat_next = 1'b1;
                else
                    words_next = words_reg + CNT_W'(1);
            end
            else if (is_mark)
            begin
                if (sents_reg == CNT_MAX)
                    sat_next = 1'b1;
                else
                    sents_next = sents_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chars_reg <= '0;
            words_reg <= '0;
            sents_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            chars_reg <= chars_next;
            words_reg <= words_next;
            sents_reg <= sents_next;
            sat_reg   <= sat_next;
        end
    end

    assign counts.chars     = chars_reg;
    assign counts.words     = words_reg;
    assign counts.sents     = sents_reg;
    assign counts.saturated = sat_reg;

endmodule

@@ sv/rgi_mul_unit.sv @@
// ----------------------------------------------------------------------------
// rgi_mul_unit
// Shared multiplier with a registered product, issued once per cycle by the
// sequencer.
// ----------------------------------------------------------------------------
module rgi_mul_unit (
    input  logic                      clk,
    input  rgi_pkg::mul_req_t         req,
    output logic [rgi_pkg::PROD_W-1:0] product
);
    import rgi_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
            prod_reg <= PROD_W'(req.a) * PROD_W'(req.b);
    end

    assign product = prod_reg;

endmodule

@@ sv/rgi_seq.sv @@
// ----------------------------------------------------------------------------
// rgi_seq
// Sequencer that builds the grade terms on the shared multiplier, walks the
// grade thresholds with one compare and add per cycle, and holds the result.
// ----------------------------------------------------------------------------
module rgi_seq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       last_accept,
    input  rgi_pkg::counts_t           counts,
    input  logic [rgi_pkg::PROD_W-1:0] product,
    output rgi_pkg::mul_req_t          mul_req,
    output logic                       idle,
    output logic                       clear,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rgi_pkg::out_item_t         out_item
);
    import rgi_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_CS    = 11'b00000000010,
        S_CS471 = 11'b00000000100,
        S_WW    = 11'b00000001000,
        S_WW50  = 11'b00000010000,
        S_WS    = 11'b00000100000,
        S_WS100 = 11'b00001000000,
        S_BASE  = 11'b00010000000,
        S_LOAD  = 11'b00100000000,
        S_CMP   = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   lhs_reg, lhs_next;
    logic [VAL_W-1:0]   thr_reg, thr_next;
    logic [VAL_W-1:0]   step_reg, step_next;
    logic [PA_W-1:0]    ws_reg, ws_next;
    logic [GRADE_W-1:0] grade_reg, grade_next;
    logic [GRADE_W-1:0] k_reg, k_next;
    logic               err_reg, err_next;
    logic               valid_reg, valid_next;
    out_item_t          item_reg, item_next;
    logic               load_out;

    always_comb
    begin
        state_next = state_reg;
        lhs_next   = lhs_reg;
        thr_next   = thr_reg;
        step_next  = step_reg;
        ws_next    = ws_reg;
        grade_next = grade_reg;
        k_next     = k_reg;
        err_next   = err_reg;
        mul_req.en = 1'b0;
        mul_req.a  = '0;
        mul_req.b  = '0;
        load_out   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (last_accept)
                    state_next = S_CS;
            end
            S_CS:
            begin
                grade_next = '0;
                if ((counts.words == '0) || (counts.sents == '0))
                begin
                    err_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    err_next   = 1'b0;
                    mul_req.en = 1'b1;
                    mul_req.a  = PA_W'(counts.chars);
                    mul_req.b  = MB_W'(counts.sents);
                    state_next = S_CS471;
                end
            end
            S_CS471:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = product[PA_W-1:0];
                mul_req.b  = K_CHARS;
                state_next = S_WW;
            end
            S_WW:
            begin
                lhs_next   = product[VAL_W-1:0];
                mul_req.en = 1'b1;
                mul_req.a  = PA_W'(counts.words);
                mul_req.b  = MB_W'(counts.words);
                state_next = S_WW50;
            end
            S_WW50:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = product[PA_W-1:0];
                mul_req.b  = K_WORDS;
                state_next = S_WS;
            end
            S_WS:
            begin
                lhs_next   = lhs_reg + product[VAL_W-1:0];
                mul_req.en = 1'b1;
                mul_req.a  = PA_W'(counts.words);
                mul_req.b  = MB_W'(counts.sents);
                state_next = S_WS100;
            end
            S_WS100:
            begin
                ws_next    = product[PA_W-1:0];
                mul_req.en = 1'b1;
                mul_req.a  = product[PA_W-1:0];
                mul_req.b  = K_STEP;
                state_next = S_BASE;
            end
            S_BASE:
            begin
                step_next  = product[VAL_W-1:0];
                mul_req.en = 1'b1;
                mul_req.a  = ws_reg;
                mul_req.b  = K_BASE;
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                thr_next   = product[VAL_W-1:0];
                k_next     = '0;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (lhs_reg >= thr_reg)
                    grade_next = grade_reg + GRADE_W'(1);
                thr_next = thr_reg + step_reg;
                k_next   = k_reg + GRADE_W'(1);
                if (k_reg == GRADE_MAX - GRADE_W'(1))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (load_out)
        begin
            valid_next                = 1'b1;
            item_next.grade_index     = grade_reg;
            item_next.count_error     = err_reg;
            item_next.count_saturated = counts.saturated;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lhs_reg   <= lhs_next;
        thr_reg   <= thr_next;
        step_reg  <= step_next;
        ws_reg    <= ws_next;
        grade_reg <= grade_next;
        k_reg     <= k_next;
        err_reg   <= err_next;
        item_reg  <= item_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign clear     = load_out;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ sv/readability_grade_index_top.sv @@
// ----------------------------------------------------------------------------
// readability_grade_index_top
// Automated Readability Index grade from a text byte stream.
// ----------------------------------------------------------------------------
// Ordinary bytes are taken one per cycle while the block is idle and only update the counters.
// A byte marked end_of_text starts a result computation, which goes straight
// to the result when the word or sentence count is zero; text_ready stays low
// meanwhile. The computation is seven products on the shared multiplier, one
// load step, a 13-step threshold compare and a final step to load the result.
// Reset clears all counters and the result slot.
module readability_grade_index_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    output logic               text_ready,
    input  rgi_pkg::in_item_t  text_item,
    output logic               grade_valid,
    input  logic               grade_ready,
    output rgi_pkg::out_item_t grade_item
);
    import rgi_pkg::*;

    counts_t           counts;
    mul_req_t          mul_req;
    logic [PROD_W-1:0] product;
    logic              accept;
    logic              idle;
    logic              clear;

    assign text_ready = idle;
    assign accept     = text_valid && idle;

    rgi_counters u_counters (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text_item.text_byte),
        .clear     (clear),
        .counts    (counts)
    );

    rgi_mul_unit u_mul (
        .clk     (clk),
        .req     (mul_req),
        .product (product)
    );

    rgi_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .last_accept (accept && text_item.end_of_text),
        .counts      (counts),
        .product     (product),
        .mul_req     (mul_req),
        .idle        (idle),
        .clear       (clear),
        .out_valid   (grade_valid),
        .out_ready   (grade_ready),
        .out_item    (grade_item)
    );

endmodule

@@ sv/rgi_checker.sv @@
// ----------------------------------------------------------------------------
// rgi_checker
// Port-level checks for the readability grade index block.
// ----------------------------------------------------------------------------
module rgi_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               text_valid,
    input logic               text_ready,
    input rgi_pkg::in_item_t  text_item,
    input logic               grade_valid,
    input logic               grade_ready,
    input rgi_pkg::out_item_t grade_item
);
    import rgi_pkg::*;

    // The final byte of a text starts the grade computation.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (text_valid && text_ready && text_item.end_of_text) |=> !text_ready)
        else $error("input still ready after final byte");

    a_grade_range: assert property (@(posedge clk) disable iff (!rst_n)
        grade_valid |-> (grade_item.grade_index <= GRADE_MAX))
        else $error("grade index above maximum");

    a_error_grade: assert property (@(posedge clk) disable iff (!rst_n)
        (grade_valid && grade_item.count_error) |-> (grade_item.grade_index == '0))
        else $error("error result with nonzero grade");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(grade_valid) |-> $past(!text_ready))
        else $error("result appeared without a computation");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (grade_valid && !grade_ready) |=> (grade_valid && $stable(grade_item)))
        else $error("stalled result changed");

endmodule

bind readability_grade_index_top rgi_checker u_rgi_checker (.*);

@@ bench/rgi_grade_check.sv @@
// ----------------------------------------------------------------------------
// rgi_grade_check
// Watches both channels of the readability grade block and checks each grade.
// It keeps its own character, word and sentence counts from every accepted text
// request and computes the grade exactly in wide integers. Each grade that
// comes out is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module rgi_grade_check (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               text_valid,
    input  logic               text_ready,
    input  rgi_pkg::in_item_t  text_item,
    input  logic               grade_valid,
    input  logic               grade_ready,
    input  rgi_pkg::out_item_t grade_item,
    output int                 fail_count,
    output int                 pending
);
    import rgi_pkg::*;

    logic [CNT_W-1:0] chars;
    logic [CNT_W-1:0] words;
    logic [CNT_W-1:0] sents;
    logic             sat_seen;
    out_item_t        grades_due[$];
    int               fails = 0;
    int               due_count = 0;

    assign fail_count = fails;
    assign pending    = due_count;

    task automatic report_mismatch(input string what);
        $display("%0t rgi_grade_check: %s", $time, what);
        fails++;
    endtask

    function automatic logic [GRADE_W-1:0] ari_grade(input logic [CNT_W-1:0] c,
                                                     input logic [CNT_W-1:0] w,
                                                     input logic [CNT_W-1:0] s);
        logic [127:0] lhs;
        lhs = 128'(471) * 128'(c) * 128'(s) + 128'(50) * 128'(w) * 128'(w);
        for (int k = int'(GRADE_MAX); k >= 1; k--)
        begin
            if (lhs >= 128'(2143 + 100 * k) * 128'(w) * 128'(s))
                return GRADE_W'(k);
        end
        return '0;
    endfunction

    task automatic tally(input logic [7:0] b);
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || (b >= "0" && b <= "9"))
        begin
            if (&chars)
                sat_seen = 1'b1;
            else
                chars++;
        end
        else if (b == " ")
        begin
            if (&words)
                sat_seen = 1'b1;
            else
                words++;
        end
        else if (b == "." || b == "?" || b == "!")
        begin
            if (&sents)
                sat_seen = 1'b1;
            else
                sents++;
        end
    endtask

    task automatic close_text();
        out_item_t g;
        g.count_error     = (words == '0) || (sents == '0);
        g.grade_index     = g.count_error ? '0 : ari_grade(chars, words, sents);
        g.count_saturated = sat_seen;
        grades_due.push_back(g);
        chars    = '0;
        words    = '0;
        sents    = '0;
        sat_seen = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t due;
        if (!rst_n)
        begin
            chars    = '0;
            words    = '0;
            sents    = '0;
            sat_seen = 1'b0;
            grades_due.delete();
            due_count = 0;
        end
        else
        begin
            if (grade_valid && grade_ready)
            begin
                if (grades_due.size() == 0)
                    report_mismatch("grade result with no text pending");
                else
                begin
                    due = grades_due.pop_front();
                    if (grade_item.grade_index !== due.grade_index)
                        report_mismatch($sformatf("grade_index %0d, expected %0d",
                                                  grade_item.grade_index, due.grade_index));
                    if (grade_item.count_error !== due.count_error)
                        report_mismatch($sformatf("count_error %b, expected %b",
                                                  grade_item.count_error, due.count_error));
                    if (grade_item.count_saturated !== due.count_saturated)
                        report_mismatch($sformatf("count_saturated %b, expected %b",
                                                  grade_item.count_saturated,
                                                  due.count_saturated));
                end
            end
            if (text_valid && text_ready)
            begin
                tally(text_item.text_byte);
                if (text_item.end_of_text)
                    close_text();
            end
            due_count = grades_due.size();
        end
    end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the readability grade index block.
// Short directed texts cover empty counts, clamping at both ends and bytes
// outside every class. Random texts of words and sentences with some noise
// follow, with random stalls on both channels. rgi_grade_check does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module tb_top;
    import rgi_pkg::*;

    localparam int RANDOM_ITEMS = 950;
    localparam int MIN_TEXTS    = 30;
    localparam int CALM_ITEMS   = 100;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 40;

    localparam string ALNUM = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    localparam string MARKS = ".?!";

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      text_valid = 1'b0;
    logic      text_ready;
    in_item_t  text_item = '0;
    logic      grade_valid;
    logic      grade_ready = 1'b0;
    out_item_t grade_item;

    int         fail_count;
    int         pending;
    bit         calm = 1'b0;
    int         items_sent = 0;
    int         ready_hold = 0;
    int         idle_cycles = 0;
    logic [7:0] text_q[$];

    readability_grade_index_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .grade_valid (grade_valid),
        .grade_ready (grade_ready),
        .grade_item  (grade_item)
    );

    rgi_grade_check checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .text_valid  (text_valid),
        .text_ready  (text_ready),
        .text_item   (text_item),
        .grade_valid (grade_valid),
        .grade_ready (grade_ready),
        .grade_item  (grade_item),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            grade_ready <= 1'b0;
        else if (calm)
            grade_ready <= 1'b1;
        else if (ready_hold > 0)
            ready_hold--;
        else if ($urandom_range(0, 3) == 0)
        begin
            grade_ready <= 1'b0;
            ready_hold = $urandom_range(0, 6);
        end
        else
        begin
            grade_ready <= 1'b1;
            ready_hold = $urandom_range(0, 15);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((text_valid && text_ready) || (grade_valid && grade_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last, input bit dense);
        text_valid            <= 1'b1;
        text_item.text_byte   <= b;
        text_item.end_of_text <= last;
        @(posedge clk);
        while (!text_ready)
            @(posedge clk);
        items_sent++;
        if (!dense && !calm && $urandom_range(0, 5) == 0)
        begin
            text_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    task automatic send_queue(input bit dense);
        for (int i = 0; i < text_q.size(); i++)
            send_byte(text_q[i], i == text_q.size() - 1, dense);
        text_q.delete();
    endtask

    task automatic load_string(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic push_word(input int max_len);
        repeat ($urandom_range(1, max_len))
            text_q.push_back(ALNUM[$urandom_range(0, ALNUM.len() - 1)]);
        if ($urandom_range(0, 19) == 0)
            text_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_text();
        int  kind;
        int  word_len;
        int  max_words;
        int  n_sents;
        int  n_words;
        bit  no_marks;
        bit  no_spaces;
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 20))
                text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        no_marks  = (kind == 1) && $urandom_range(0, 1);
        no_spaces = (kind == 1) && !no_marks;
        word_len  = $urandom_range(1, 12);
        max_words = ($urandom_range(0, 5) == 0) ? 14 : 5;
        n_sents   = $urandom_range(1, 2);
        for (int s = 0; s < n_sents; s++)
        begin
            n_words = $urandom_range(1, max_words);
            for (int w = 0; w < n_words; w++)
            begin
                push_word(word_len);
                if (w < n_words - 1 && !no_spaces)
                    text_q.push_back(" ");
            end
            if (!no_marks)
                text_q.push_back(MARKS[$urandom_range(0, 2)]);
            if (!no_spaces && (s < n_sents - 1 || $urandom_range(0, 1)))
                text_q.push_back(" ");
        end
    endtask

    initial
    begin
        int random_start;
        int texts_done;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_string(".");
        send_queue(1'b0);
        load_string(" ");
        send_queue(1'b0);
        text_q = '{8'h00, 8'h7F, 8'h80, 8'hFF};
        load_string("@[`{/: Ab 9z.");
        send_queue(1'b0);
        load_string("Zebra09x !");
        send_queue(1'b0);

        random_start = items_sent;
        texts_done   = 0;
        while (items_sent - random_start < RANDOM_ITEMS || texts_done < MIN_TEXTS)
        begin
            if (items_sent - random_start >= RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            build_text();
            send_queue($urandom_range(0, 3) == 0);
            texts_done++;
        end
        text_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
